// ===== rtl/priority_lru_victim_select_top_macros.svh =====
// Assertion macros shared by the priority LRU victim select design.
`ifndef PRIORITY_LRU_VICTIM_SELECT_TOP_MACROS_SVH
`define PRIORITY_LRU_VICTIM_SELECT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define PRLV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PRLV_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define PRLV_ASSERT(label, prop, msg)
`define PRLV_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/prlv_pkg.sv =====
// Shared constants and item codes for the priority LRU victim select block.
`timescale 1ns / 1ps

package prlv_pkg;

    localparam int SETS_DEF  = 256;
    localparam int WAYS_DEF  = 16;
    localparam int CORES_DEF = 4;

    localparam int KIND_W   = 2;
    localparam int CPU_W    = 2;
    localparam int SETIDX_W = 8;
    localparam int WAYIDX_W = 4;
    localparam int THR_W    = 5;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(4);

    localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT   = 2'd2;

endpackage

// ===== rtl/priority_lru_victim_select_top.sv =====
// Priority LRU victim select: item control, row memory, update and victim logic.
// Access and query words each read the row, then write it back or evaluate it.
// A query result is registered in the execute state after the row read; a held result stalls the next query.
// An init word writes one row per core for its set; an unused kind is accepted and dropped.
// After reset a clearing pass writes all 2**(core bits + set bits) rows (1024 by default)
// before the first word is accepted; the threshold resets to 4.
`timescale 1ns / 1ps
`include "priority_lru_victim_select_top_macros.svh"

module priority_lru_victim_select_top #(
    parameter int SETS  = prlv_pkg::SETS_DEF,
    parameter int WAYS  = prlv_pkg::WAYS_DEF,
    parameter int CORES = prlv_pkg::CORES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [prlv_pkg::THR_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [prlv_pkg::KIND_W-1:0]   s_kind,
    input  logic [prlv_pkg::CPU_W-1:0]    s_cpu_id,
    input  logic [prlv_pkg::SETIDX_W-1:0] s_set_index,
    input  logic [prlv_pkg::WAYIDX_W-1:0] s_way_index,
    input  logic                          s_high_priority,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [prlv_pkg::WAYIDX_W-1:0] m_victim_way
);

    localparam int WAY_W  = $clog2(WAYS);
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int ADDR_W = CORE_W + SET_W;
    localparam int ROW_W  = WAYS * (WAY_W + 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_INIT  = 4'b1000
    } state_t;

    function automatic logic [7:0] fold8(input logic [7:0] v, input int unsigned m);
        logic [31:0] r;
        r = 32'(v);
        for (int k = 7; k >= 0; k--) begin
            if (r >= (32'(m) << k)) begin
                r = r - (32'(m) << k);
            end
        end
        return 8'(r);
    endfunction

    function automatic logic [ROW_W-1:0] init_row();
        logic [WAYS-1:0][WAY_W-1:0] r;
        for (int w = 0; w < WAYS; w++) begin
            r[w] = WAY_W'(w);
        end
        return {r, {WAYS{1'b0}}};
    endfunction

    state_t                        state_reg, state_next;
    logic [prlv_pkg::THR_W-1:0]    threshold_reg;
    logic [ADDR_W-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [CORE_W-1:0]             init_core_reg, init_core_next;
    logic [prlv_pkg::KIND_W-1:0]   kind_reg;
    logic [CORE_W-1:0]             core_reg;
    logic [SET_W-1:0]              set_reg;
    logic [WAY_W-1:0]              way_reg;
    logic                          prio_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [prlv_pkg::WAYIDX_W-1:0] m_victim_reg, m_victim_next;

    logic                          accept;
    logic [CORE_W-1:0]             in_core;
    logic [SET_W-1:0]              in_set;
    logic                          way_ok;

    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ROW_W-1:0]              wr_data;
    logic                          rd_en;
    logic [ROW_W-1:0]              rd_data;
    logic [WAYS-1:0]               rd_prio;
    logic [WAYS-1:0][WAY_W-1:0]    rd_rank;
    logic [WAYS-1:0]               upd_prio;
    logic [WAYS-1:0][WAY_W-1:0]    upd_rank;
    logic [WAY_W-1:0]              pick_way;

    assign s_ready      = state_reg == ST_IDLE;
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_victim_way = m_victim_reg;

    assign in_core = CORE_W'(fold8(8'(s_cpu_id), CORES));
    assign in_set  = SET_W'(fold8(s_set_index, SETS));
    assign way_ok  = 32'(s_way_index) < 32'(WAYS);

    assign rd_en = accept && ((s_kind == prlv_pkg::KIND_QUERY) ||
                              ((s_kind == prlv_pkg::KIND_ACCESS) && way_ok));

    assign rd_prio = rd_data[WAYS-1:0];
    assign rd_rank = rd_data[ROW_W-1:WAYS];

    prlv_mem #(
        .ADDR_W (ADDR_W),
        .ROW_W  (ROW_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr ({in_core, in_set}),
        .rd_data (rd_data)
    );

    prlv_update #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_update (
        .old_prio (rd_prio),
        .old_rank (rd_rank),
        .way      (way_reg),
        .prio     (prio_reg),
        .new_prio (upd_prio),
        .new_rank (upd_rank)
    );

    prlv_pick #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_pick (
        .prio      (rd_prio),
        .rank      (rd_rank),
        .threshold (threshold_reg),
        .victim    (pick_way)
    );

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        init_core_next = init_core_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_victim_next  = m_victim_reg;
        wr_en          = 1'b0;
        wr_addr        = {core_reg, set_reg};
        wr_data        = {upd_rank, upd_prio};
        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = init_row();
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (rd_en) begin
                        state_next = ST_EXEC;
                    end else if (s_kind == prlv_pkg::KIND_INIT) begin
                        init_core_next = '0;
                        state_next     = ST_INIT;
                    end
                end
            end
            ST_EXEC: begin
                if (kind_reg == prlv_pkg::KIND_ACCESS) begin
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_victim_next = prlv_pkg::WAYIDX_W'(pick_way);
                    state_next    = ST_IDLE;
                end
            end
            ST_INIT: begin
                wr_en          = 1'b1;
                wr_addr        = {init_core_reg, set_reg};
                wr_data        = init_row();
                init_core_next = init_core_reg + CORE_W'(1);
                if (init_core_reg == CORE_W'(CORES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            init_core_reg <= '0;
            m_valid_reg   <= 1'b0;
            threshold_reg <= prlv_pkg::THRESHOLD_RESET;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            init_core_reg <= init_core_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                threshold_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_victim_reg <= m_victim_next;
        if (accept) begin
            kind_reg <= s_kind;
            core_reg <= in_core;
            set_reg  <= in_set;
            way_reg  <= WAY_W'(s_way_index);
            prio_reg <= s_high_priority;
        end
    end

    `PRLV_ASSERT_NEVER(a_no_rd_wr_overlap, wr_en && rd_en, "Row read and write in the same cycle.")
    `PRLV_ASSERT(a_read_goes_exec, rd_en |=> state_reg == ST_EXEC, "Row read not followed by execute.")
    `PRLV_ASSERT(a_result_from_query, $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC) && $past(kind_reg == prlv_pkg::KIND_QUERY), "Result word without a victim query.")

endmodule

// ===== rtl/prlv_mem.sv =====
// Replacement state memory: one row per core and set, one write and one registered read port.
`timescale 1ns / 1ps

module prlv_mem #(
    parameter int ADDR_W = 10,
    parameter int ROW_W  = 80
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/prlv_update.sv =====
// Access update of one row: stores the priority and moves the way to the most recent rank.
`timescale 1ns / 1ps

module prlv_update #(
    parameter int WAYS  = 16,
    parameter int WAY_W = 4
) (
    input  logic [WAYS-1:0]             old_prio,
    input  logic [WAYS-1:0][WAY_W-1:0]  old_rank,
    input  logic [WAY_W-1:0]            way,
    input  logic                        prio,
    output logic [WAYS-1:0]             new_prio,
    output logic [WAYS-1:0][WAY_W-1:0]  new_rank
);

    logic [WAY_W-1:0] way_rank;

    assign way_rank = old_rank[way];

    always_comb begin
        new_prio = old_prio;
        new_prio[way] = prio;
        for (int w = 0; w < WAYS; w++) begin
            if (old_rank[w] < way_rank) begin
                new_rank[w] = old_rank[w] + WAY_W'(1);
            end else begin
                new_rank[w] = old_rank[w];
            end
        end
        new_rank[way] = '0;
    end

endmodule

// ===== rtl/prlv_pick.sv =====
// Victim selection over one row: group choice by priority count, then an oldest-way compare tree.
`timescale 1ns / 1ps

module prlv_pick #(
    parameter int WAYS  = 16,
    parameter int WAY_W = 4
) (
    input  logic [WAYS-1:0]                 prio,
    input  logic [WAYS-1:0][WAY_W-1:0]      rank,
    input  logic [prlv_pkg::THR_W-1:0]      threshold,
    output logic [WAY_W-1:0]                victim
);

    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int LEAVES = 1 << WAY_W;

    logic [CNT_W-1:0] hi_count;
    logic             group;
    logic [WAY_W:0]   key [1:2*LEAVES-1];
    logic [WAY_W-1:0] idx [1:2*LEAVES-1];

    always_comb begin
        hi_count = '0;
        for (int w = 0; w < WAYS; w++) begin
            hi_count = hi_count + CNT_W'(prio[w]);
        end
    end

    assign group = 32'(hi_count) > 32'(threshold);

    // Members of the chosen group sort above all others, so an empty group
    // falls back to the oldest way overall. Ties keep the lower way.
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < WAYS) begin : g_real
            assign key[LEAVES+i] = {prio[i] == group, rank[i]};
        end else begin : g_pad
            assign key[LEAVES+i] = '0;
        end
        assign idx[LEAVES+i] = WAY_W'(i);
    end

    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        assign key[n] = (key[2*n+1] > key[2*n]) ? key[2*n+1] : key[2*n];
        assign idx[n] = (key[2*n+1] > key[2*n]) ? idx[2*n+1] : idx[2*n];
    end

    assign victim = idx[1];

endmodule
